### sv/rfid_em4100_edge_decoder_assert.svh
// ----------------------------------------------------------------------------
// EM4100 edge decoder assertion macros
// Concurrent check macros shared by the decoder RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef RFID_EM4100_EDGE_DECODER_ASSERT_SVH
`define RFID_EM4100_EDGE_DECODER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define EM41_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("em4100 decoder: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define EM41_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("em4100 decoder: next-cycle check failed");

`else

`define EM41_ASSERT_SAME(lbl, ante, cons)
`define EM41_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/em41_pkg.sv
// ----------------------------------------------------------------------------
// EM4100 edge decoder package
// Shared widths, constants, register map and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package em41_pkg;

    localparam int HEADER_ONES = 9;
    localparam int FRAME_BITS  = 55;
    localparam int ROWS        = 10;
    localparam int ID_W        = 40;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [15:0] LONG_GAP_RST  = 16'd160;
    localparam logic [15:0] BIT_GAP_RST   = 16'd92;
    localparam logic [7:0]  SEEN_TIME_RST = 8'd250;
    localparam logic [15:0] REF_RELOAD    = 16'hFFFF;

    localparam logic [1:0] REG_LONG_GAP  = 2'd0;
    localparam logic [1:0] REG_BIT_GAP   = 2'd1;
    localparam logic [1:0] REG_SEEN_TIME = 2'd2;
    localparam logic [1:0] REG_ERR_TOTAL = 2'd3;

    typedef struct packed {
        logic [15:0] timer_count;
        logic        demod_level;
    } edge_req_t;

    typedef struct packed {
        logic            timer_restart;
        logic            frame_done;
        logic            frame_ok;
        logic [ID_W-1:0] card_id;
        logic            card_new;
        logic            card_pending;
    } result_t;

    typedef struct packed {
        logic [15:0] long_gap_ticks;
        logic [15:0] bit_gap_ticks;
        logic [7:0]  seen_timeout;
    } cfg_t;

    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] id;
    } chk_t;

endpackage

`default_nettype wire

### sv/em41_cfg.sv
// ----------------------------------------------------------------------------
// EM4100 edge decoder configuration registers
// APB-style register bank for gap thresholds and seen-card timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module em41_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [em41_pkg::ADDR_W-1:0] paddr,
    input  wire logic [em41_pkg::DATA_W-1:0] pwdata,
    output logic      [em41_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic [em41_pkg::DATA_W-1:0] error_total,
    output em41_pkg::cfg_t                   cfg
);
    import em41_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_gap_ticks <= LONG_GAP_RST;
            cfg_reg.bit_gap_ticks  <= BIT_GAP_RST;
            cfg_reg.seen_timeout   <= SEEN_TIME_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LONG_GAP:  cfg_reg.long_gap_ticks <= pwdata[15:0];
                REG_BIT_GAP:   cfg_reg.bit_gap_ticks  <= pwdata[15:0];
                REG_SEEN_TIME: cfg_reg.seen_timeout   <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LONG_GAP:  prdata = {16'd0, cfg_reg.long_gap_ticks};
            REG_BIT_GAP:   prdata = {16'd0, cfg_reg.bit_gap_ticks};
            REG_SEEN_TIME: prdata = {24'd0, cfg_reg.seen_timeout};
            REG_ERR_TOTAL: prdata = error_total;
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/em41_frame_check.sv
// ----------------------------------------------------------------------------
// EM4100 frame checker
// Row parity, column parity, stop bit and nonzero-ID check of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module em41_frame_check (
    input  wire logic [em41_pkg::FRAME_BITS-1:0] frame,
    output em41_pkg::chk_t                       chk
);
    import em41_pkg::*;

    logic [ID_W-1:0] id;
    logic [3:0]      colx;
    logic [ROWS-1:0] row_ok;

    always_comb
    begin
        colx = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            id[ID_W-1-4*r -: 4] = {frame[5*r], frame[5*r+1], frame[5*r+2], frame[5*r+3]};
            row_ok[r] = ((frame[5*r] ^ frame[5*r+1] ^ frame[5*r+2] ^ frame[5*r+3])
                         == frame[5*r+4]);
            colx = colx ^ {frame[5*r], frame[5*r+1], frame[5*r+2], frame[5*r+3]};
        end
    end

    assign chk.id = id;
    assign chk.ok = (&row_ok)
                 && (colx == {frame[50], frame[51], frame[52], frame[53]})
                 && !frame[54]
                 && (id != '0);

endmodule

`default_nettype wire

### sv/em41_core.sv
// ----------------------------------------------------------------------------
// EM4100 edge decoder core
// Gap classification, header search, frame capture and card latch.
// ----------------------------------------------------------------------------
`default_nettype none

module em41_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire em41_pkg::edge_req_t         req,
    input  wire em41_pkg::cfg_t              cfg,
    output em41_pkg::result_t                result,
    output logic      [em41_pkg::DATA_W-1:0] error_total
);
    import em41_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    localparam logic [CNT_W-1:0] HEADER_CNT = CNT_W'(HEADER_ONES);
    localparam logic [CNT_W-1:0] FRAME_CNT  = CNT_W'(FRAME_BITS);

    phase_t                phase_reg,   phase_next;
    logic [15:0]           ref_reg,     ref_next;
    logic [CNT_W-1:0]      bcnt_reg,    bcnt_next;
    logic [FRAME_BITS-1:0] frame_reg,   frame_next;
    logic [ID_W-1:0]       id_reg,      id_next;
    logic                  seen_reg,    seen_next;
    logic                  pend_reg,    pend_next;
    logic [7:0]            age_reg,     age_next;
    logic [DATA_W-1:0]     err_reg,     err_next;

    chk_t             chk;
    logic             gap_long;
    logic             gap_bit;
    logic [8:0]       age_inc;
    logic [CNT_W-1:0] bcnt_inc;
    logic [CNT_W-1:0] bit_idx;
    logic             restart;
    logic             done;
    logic             ok;
    logic             is_new;

    em41_frame_check u_check (
        .frame (frame_next),
        .chk   (chk)
    );

    assign gap_long = (phase_reg == PH_IDLE)
                   || ({1'b0, ref_reg} > ({1'b0, req.timer_count} + {1'b0, cfg.long_gap_ticks}));
    assign gap_bit  = {1'b0, ref_reg} > ({1'b0, req.timer_count} + {1'b0, cfg.bit_gap_ticks});
    assign age_inc  = {1'b0, age_reg} + 9'd1;
    assign bcnt_inc = bcnt_reg + CNT_W'(1);
    assign bit_idx  = bcnt_inc - CNT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        ref_next   = ref_reg;
        bcnt_next  = bcnt_reg;
        frame_next = frame_reg;
        id_next    = id_reg;
        seen_next  = seen_reg;
        pend_next  = pend_reg;
        age_next   = age_reg;
        err_next   = err_reg;
        restart    = 1'b0;
        done       = 1'b0;
        ok         = 1'b0;
        is_new     = 1'b0;

        if (gap_long)
        begin
            if (req.demod_level)
            begin
                restart    = 1'b1;
                ref_next   = REF_RELOAD;
                bcnt_next  = CNT_W'(1);
                phase_next = PH_HEADER;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
            if (seen_reg)
            begin
                if (age_inc > {1'b0, cfg.seen_timeout})
                begin
                    seen_next = 1'b0;
                end
                age_next = age_inc[8] ? 8'hFF : age_inc[7:0];
            end
        end
        else if (gap_bit)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (bcnt_reg >= HEADER_CNT)
                    begin
                        frame_next = {{(FRAME_BITS-1){1'b0}}, req.demod_level};
                        bcnt_next  = CNT_W'(1);
                        phase_next = PH_DATA;
                    end
                    else if (req.demod_level)
                    begin
                        bcnt_next = bcnt_inc;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    bcnt_next = bcnt_inc;
                    if (req.demod_level && (bcnt_inc != '0) && (bcnt_inc <= FRAME_CNT))
                    begin
                        frame_next[bit_idx] = 1'b1;
                    end
                    if (bcnt_inc >= FRAME_CNT)
                    begin
                        done = 1'b1;
                        if (chk.ok)
                        begin
                            ok = 1'b1;
                            if (!seen_reg || (chk.id != id_reg))
                            begin
                                id_next   = chk.id;
                                seen_next = 1'b1;
                                pend_next = 1'b1;
                                is_new    = 1'b1;
                            end
                            age_next = '0;
                        end
                        else
                        begin
                            err_next = err_reg + DATA_W'(1);
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default: ;
            endcase
            ref_next = req.timer_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ref_reg   <= '0;
            bcnt_reg  <= '0;
            frame_reg <= '0;
            id_reg    <= '0;
            seen_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            age_reg   <= '0;
            err_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ref_reg   <= ref_next;
            bcnt_reg  <= bcnt_next;
            frame_reg <= frame_next;
            id_reg    <= id_next;
            seen_reg  <= seen_next;
            pend_reg  <= pend_next;
            age_reg   <= age_next;
            err_reg   <= err_next;
        end
    end

    assign result.timer_restart = restart;
    assign result.frame_done    = done;
    assign result.frame_ok      = ok;
    assign result.card_id       = id_next;
    assign result.card_new      = is_new;
    assign result.card_pending  = pend_next;
    assign error_total          = err_reg;

endmodule

`default_nettype wire

### sv/rfid_em4100_edge_decoder.sv
// ----------------------------------------------------------------------------
// EM4100 RFID edge decoder
// Sorts tag-signal edges by gap, decodes the 64-bit Manchester frame and
// latches valid card IDs.
//
// Usage:
//   edge_valid/edge_stall/edge_data carry one request per demodulated edge
//   (captured down-counter value and line level). res_valid/res_stall/res_data
//   return exactly one result per request: timer restart, frame status and the
//   latched card ID with its pending flag.
//   Results are registered: res_valid rises in the cycle after a request is accepted.
//   Throughput: one request per cycle while edge_stall is low; the state update and the frame check
//   sit in one combinational pass between the state registers and the result
//   register.
//   While res_stall holds a waiting result, edge_stall rises and the result
//   register holds; requests resume in the cycle the result is taken.
//   Reset clears the decoder to idle with no card latched and loads the
//   threshold registers with their defaults (160, 92, 250).
//   APB registers: 0x0 long gap, 0x4 bit gap, 0x8 seen timeout,
//   0xC failed-frame count (read only).
// ----------------------------------------------------------------------------
`default_nettype none

`include "rfid_em4100_edge_decoder_assert.svh"

module rfid_em4100_edge_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        edge_valid,
    output logic                             edge_stall,
    input  wire em41_pkg::edge_req_t         edge_data,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output em41_pkg::result_t                res_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [em41_pkg::ADDR_W-1:0] paddr,
    input  wire logic [em41_pkg::DATA_W-1:0] pwdata,
    output logic      [em41_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import em41_pkg::*;

    cfg_t              cfg;
    result_t           result;
    result_t           res_data_reg;
    logic              res_valid_reg;
    logic              accept;
    logic [DATA_W-1:0] error_total;

    assign edge_stall = res_valid_reg && res_stall;
    assign accept     = edge_valid && !edge_stall;

    em41_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .error_total (error_total),
        .cfg         (cfg)
    );

    em41_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (edge_data),
        .cfg         (cfg),
        .result      (result),
        .error_total (error_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_data_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `EM41_ASSERT_NEXT(a_accept_gives_result, accept, res_valid)
    `EM41_ASSERT_SAME(a_ok_needs_done, res_valid && res_data.frame_ok, res_data.frame_done)
    `EM41_ASSERT_SAME(a_new_needs_ok, res_valid && res_data.card_new, res_data.frame_ok)
    `EM41_ASSERT_SAME(a_new_sets_pending, res_valid && res_data.card_new, res_data.card_pending)

endmodule

`default_nettype wire
